// ----- rtl/rtch_pkg.sv -----
// ----------------------------------------------------------------------------
// rtch_pkg: shared types and constants of the closest-hit unit
// Widths of the exact intermediates, the term table that drives the shared
// multiply-accumulate unit, and the command struct between sequencer and MAC.
// ----------------------------------------------------------------------------
package rtch_pkg;

   // number formats
   localparam int FRAC_BITS = 16;
   localparam int ID_BITS   = 16;
   localparam int COORD_W   = 32;
   localparam int S_W       = COORD_W + 1;          // origin minus vertex0
   localparam int A_W       = S_W;                  // multiplier short operand
   localparam int B_W       = 2 * COORD_W + 2;      // cross product terms
   localparam int CH_W      = 17;                   // long operand digit
   localparam int N_CH      = (B_W + CH_W - 1) / CH_W;
   localparam int BX_W      = N_CH * CH_W;
   localparam int PROD_W    = A_W + CH_W + 1;
   localparam int ACC_W     = 104;
   localparam int DOT_W     = 100;                  // det, u, v, t numerators
   localparam int DEN_W     = 97;                   // |det|
   localparam int NUM_W     = 99;                   // folded numerator
   localparam int QUO_W     = FRAC_BITS + 2;        // quotient up to 2.0
   localparam int REM_W     = NUM_W + FRAC_BITS;
   localparam int EPS_W     = 40;
   localparam int RES_W     = 17;
   localparam int TERM_W    = 5;

   localparam logic [EPS_W-1:0]  EPS_RESET = 40'd2814749767;
   localparam logic [QUO_W-1:0]  ONE_Q     = QUO_W'(1 << FRAC_BITS);
   localparam logic [TERM_W-1:0] TERM_DET_END = 5'd8;
   localparam logic [TERM_W-1:0] TERM_LAST    = 5'd23;

   // request commands
   localparam logic CMD_RAY = 1'b0;
   localparam logic CMD_TRI = 1'b1;

   // operand sources and result destinations
   typedef enum logic [1:0] {A_DIR, A_E1, A_E2, A_S} a_src_type;
   typedef enum logic [1:0] {B_E1, B_E2, B_PERP, B_Q} b_src_type;
   typedef enum logic [3:0] {
      D_PERP0, D_PERP1, D_PERP2, D_DET, D_Q0, D_Q1, D_Q2, D_UN, D_VN, D_TN
   } dest_type;

   typedef struct packed {
      a_src_type  a_sel;
      logic [1:0] a_idx;
      b_src_type  b_sel;
      logic [1:0] b_idx;
      logic       neg;
      logic       clear;
      dest_type   dest;
   } term_type;

   typedef struct packed {
      logic go;
      logic clear;
      logic neg;
   } mac_cmd_type;

   function automatic term_type mk_term(a_src_type a_s, logic [1:0] a_i, b_src_type b_s,
                                        logic [1:0] b_i, logic ng, logic cl, dest_type ds);
      term_type t;
      t.a_sel = a_s;
      t.a_idx = a_i;
      t.b_sel = b_s;
      t.b_idx = b_i;
      t.neg   = ng;
      t.clear = cl;
      t.dest  = ds;
      return t;
   endfunction

   // one product per row: perp = dir x e2, det, q = s x e1, u, v, t
   function automatic term_type term_lookup(logic [TERM_W-1:0] idx);
      term_type r;
      unique case (idx)
         5'd0:  r = mk_term(A_DIR, 2'd1, B_E2,   2'd2, 1'b0, 1'b1, D_PERP0);
         5'd1:  r = mk_term(A_DIR, 2'd2, B_E2,   2'd1, 1'b1, 1'b0, D_PERP0);
         5'd2:  r = mk_term(A_DIR, 2'd2, B_E2,   2'd0, 1'b0, 1'b1, D_PERP1);
         5'd3:  r = mk_term(A_DIR, 2'd0, B_E2,   2'd2, 1'b1, 1'b0, D_PERP1);
         5'd4:  r = mk_term(A_DIR, 2'd0, B_E2,   2'd1, 1'b0, 1'b1, D_PERP2);
         5'd5:  r = mk_term(A_DIR, 2'd1, B_E2,   2'd0, 1'b1, 1'b0, D_PERP2);
         5'd6:  r = mk_term(A_E1,  2'd0, B_PERP, 2'd0, 1'b0, 1'b1, D_DET);
         5'd7:  r = mk_term(A_E1,  2'd1, B_PERP, 2'd1, 1'b0, 1'b0, D_DET);
         5'd8:  r = mk_term(A_E1,  2'd2, B_PERP, 2'd2, 1'b0, 1'b0, D_DET);
         5'd9:  r = mk_term(A_S,   2'd1, B_E1,   2'd2, 1'b0, 1'b1, D_Q0);
         5'd10: r = mk_term(A_S,   2'd2, B_E1,   2'd1, 1'b1, 1'b0, D_Q0);
         5'd11: r = mk_term(A_S,   2'd2, B_E1,   2'd0, 1'b0, 1'b1, D_Q1);
         5'd12: r = mk_term(A_S,   2'd0, B_E1,   2'd2, 1'b1, 1'b0, D_Q1);
         5'd13: r = mk_term(A_S,   2'd0, B_E1,   2'd1, 1'b0, 1'b1, D_Q2);
         5'd14: r = mk_term(A_S,   2'd1, B_E1,   2'd0, 1'b1, 1'b0, D_Q2);
         5'd15: r = mk_term(A_S,   2'd0, B_PERP, 2'd0, 1'b0, 1'b1, D_UN);
         5'd16: r = mk_term(A_S,   2'd1, B_PERP, 2'd1, 1'b0, 1'b0, D_UN);
         5'd17: r = mk_term(A_S,   2'd2, B_PERP, 2'd2, 1'b0, 1'b0, D_UN);
         5'd18: r = mk_term(A_DIR, 2'd0, B_Q,    2'd0, 1'b0, 1'b1, D_VN);
         5'd19: r = mk_term(A_DIR, 2'd1, B_Q,    2'd1, 1'b0, 1'b0, D_VN);
         5'd20: r = mk_term(A_DIR, 2'd2, B_Q,    2'd2, 1'b0, 1'b0, D_VN);
         5'd21: r = mk_term(A_E2,  2'd0, B_Q,    2'd0, 1'b0, 1'b1, D_TN);
         5'd22: r = mk_term(A_E2,  2'd1, B_Q,    2'd1, 1'b0, 1'b0, D_TN);
         5'd23: r = mk_term(A_E2,  2'd2, B_Q,    2'd2, 1'b0, 1'b0, D_TN);
         default: r = mk_term(A_DIR, 2'd0, B_E1, 2'd0, 1'b0, 1'b1, D_PERP0);
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/rtch_mac.sv -----
// ----------------------------------------------------------------------------
// rtch_mac: shared digit-serial multiply-accumulate unit
// Multiplies a 33-bit signed operand by a 66-bit signed operand one 17-bit
// digit per cycle, with the product registered before it is accumulated.
// ----------------------------------------------------------------------------
module rtch_mac
   import rtch_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  mac_cmd_type             cmd,
   input  logic signed [A_W-1:0]   op_a,
   input  logic signed [B_W-1:0]   op_b,
   output logic                    done,
   output logic signed [ACC_W-1:0] acc
);

   localparam int CNT_W = $clog2(N_CH + 1);

   logic                    busy_ff;
   logic                    done_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic signed [A_W-1:0]   a_ff;
   logic signed [BX_W-1:0]  b_ff;
   logic                    neg_ff;
   logic signed [ACC_W-1:0] pp_ff;
   logic signed [ACC_W-1:0] acc_ff;

   logic signed [CH_W:0]    digit;
   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0] prod_sh;

   // top digit carries the sign, lower digits are unsigned
   always_comb begin
      if (cnt_ff == CNT_W'(N_CH - 1)) begin
         digit = b_ff[CH_W:0];
      end else begin
         digit = {1'b0, b_ff[CH_W-1:0]};
      end
      prod    = PROD_W'(a_ff * digit);
      prod_sh = ACC_W'(prod) <<< (CH_W * cnt_ff);
   end

   // digit sequencing and accumulation
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.go) begin
            a_ff    <= op_a;
            b_ff    <= BX_W'(op_b);
            neg_ff  <= cmd.neg;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
            if (cmd.clear) begin
               acc_ff <= '0;
            end
         end else if (busy_ff) begin
            if (cnt_ff != '0) begin
               acc_ff <= neg_ff ? acc_ff - pp_ff : acc_ff + pp_ff;
            end
            if (cnt_ff == CNT_W'(N_CH)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               pp_ff  <= prod_sh;
               b_ff   <= b_ff >>> CH_W;
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign acc  = acc_ff;

endmodule

// ----- rtl/rtch_div.sv -----
// ----------------------------------------------------------------------------
// rtch_div: restoring divider, one quotient bit per cycle
// Computes floor(num * 2^FRAC_BITS / den) for num no larger than twice den.
// ----------------------------------------------------------------------------
module rtch_div
   import rtch_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [QUO_W-1:0] quo
);

   localparam int CNT_W = $clog2(QUO_W);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [REM_W-1:0] rem_ff;
   logic [REM_W-1:0] dsh_ff;
   logic [QUO_W-1:0] quo_ff;
   logic             fits;

   assign fits = (rem_ff >= dsh_ff);

   // shift-subtract iteration
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            rem_ff  <= REM_W'(num) << FRAC_BITS;
            dsh_ff  <= REM_W'(den) << (FRAC_BITS + 1);
            quo_ff  <= '0;
            cnt_ff  <= CNT_W'(QUO_W - 1);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (fits) begin
               rem_ff <= rem_ff - dsh_ff;
            end
            quo_ff <= {quo_ff[QUO_W-2:0], fits};
            dsh_ff <= dsh_ff >> 1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ----- rtl/ray_triangle_closest_hit_unit.sv -----
// Start-ray beat: taken while idle; the unit stays idle and ready on the next cycle.
// Triangle beat: up to 24 products on one shared multiply-accumulate unit, then up
// to three divisions. A determinant reject ends once the determinant is known, a
// bounds reject skips the divisions, and a distance reject follows the t division.
// One beat in flight; a last triangle also waits while a stalled result is held.
// Synchronous active-high reset clears the ray and best hit, det_epsilon to default.
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit_unit: closest-hit ray/triangle search
// Exact fixed-point Moller-Trumbore test per triangle, keeping the nearest
// hit of the current ray and reporting it on the ray's last triangle.
// ----------------------------------------------------------------------------
module ray_triangle_closest_hit_unit
   import rtch_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_cmd,
   input  logic signed [COORD_W-1:0] req_a_x,
   input  logic signed [COORD_W-1:0] req_a_y,
   input  logic signed [COORD_W-1:0] req_a_z,
   input  logic signed [COORD_W-1:0] req_b_x,
   input  logic signed [COORD_W-1:0] req_b_y,
   input  logic signed [COORD_W-1:0] req_b_z,
   input  logic signed [COORD_W-1:0] req_c_x,
   input  logic signed [COORD_W-1:0] req_c_y,
   input  logic signed [COORD_W-1:0] req_c_z,
   input  logic [ID_BITS-1:0]        req_tri_id,
   input  logic                      req_last,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_hit,
   output logic [RES_W-1:0]          rsp_hit_t,
   output logic [RES_W-1:0]          rsp_hit_u,
   output logic [RES_W-1:0]          rsp_hit_v,
   output logic [ID_BITS-1:0]        rsp_hit_id,
   input  logic                      csr_wr_en,
   input  logic [EPS_W-1:0]          csr_wr_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_ISSUE, S_WAIT, S_DET, S_FOLD, S_CHK,
      S_DIVT, S_WAITT, S_DIVU, S_WAITU, S_DIVV, S_WAITV, S_FIN
   } state_type;

   state_type state_ff;

   logic signed [COORD_W-1:0] org_ff  [3];
   logic signed [COORD_W-1:0] dir_ff  [3];
   logic signed [COORD_W-1:0] e1_ff   [3];
   logic signed [COORD_W-1:0] e2_ff   [3];
   logic signed [S_W-1:0]     s_ff    [3];
   logic signed [B_W-1:0]     perp_ff [3];
   logic signed [B_W-1:0]     q_ff    [3];
   logic signed [DOT_W-1:0]   det_ff;
   logic signed [DOT_W-1:0]   un_ff;
   logic signed [DOT_W-1:0]   vn_ff;
   logic signed [DOT_W-1:0]   tn_ff;
   logic [DEN_W-1:0]          d_ff;
   logic                      neg_ff;
   logic [QUO_W-1:0]          tq_ff;
   logic [QUO_W-1:0]          uq_ff;
   logic [ID_BITS-1:0]        id_ff;
   logic                      last_ff;
   logic [TERM_W-1:0]         term_ff;
   logic [EPS_W-1:0]          eps_ff;
   logic [QUO_W-1:0]          best_t_ff;
   logic [QUO_W-1:0]          best_u_ff;
   logic [QUO_W-1:0]          best_v_ff;
   logic [ID_BITS-1:0]        best_id_ff;
   logic                      found_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_hit_ff;
   logic [RES_W-1:0]          rsp_t_ff;
   logic [RES_W-1:0]          rsp_u_ff;
   logic [RES_W-1:0]          rsp_v_ff;
   logic [ID_BITS-1:0]        rsp_id_ff;

   term_type                  term;
   mac_cmd_type               mac_cmd;
   logic signed [A_W-1:0]     op_a;
   logic signed [B_W-1:0]     op_b;
   logic                      mac_done;
   logic signed [ACC_W-1:0]   mac_acc;
   logic                      div_go;
   logic [NUM_W-1:0]          div_num;
   logic                      div_done;
   logic [QUO_W-1:0]          div_quo;
   logic [DOT_W-1:0]          det_mag;
   logic [DEN_W-1:0]          d_cand;
   logic                      det_rej;
   logic signed [DOT_W:0]     d_x;
   logic signed [DOT_W:0]     un_x;
   logic signed [DOT_W:0]     vn_x;
   logic signed [DOT_W:0]     tn_x;
   logic                      bound_rej;
   logic                      rsp_free;
   logic                      rsp_load;

   // operand selection for the current product
   always_comb begin
      term = term_lookup(term_ff);
      case (term.a_sel)
         A_DIR:   op_a = A_W'(dir_ff[term.a_idx]);
         A_E1:    op_a = A_W'(e1_ff[term.a_idx]);
         A_E2:    op_a = A_W'(e2_ff[term.a_idx]);
         default: op_a = s_ff[term.a_idx];
      endcase
      case (term.b_sel)
         B_E1:    op_b = B_W'(e1_ff[term.b_idx]);
         B_E2:    op_b = B_W'(e2_ff[term.b_idx]);
         B_PERP:  op_b = perp_ff[term.b_idx];
         default: op_b = q_ff[term.b_idx];
      endcase
      mac_cmd.go    = (state_ff == S_ISSUE);
      mac_cmd.clear = term.clear;
      mac_cmd.neg   = term.neg;
   end

   // determinant magnitude and epsilon reject
   always_comb begin
      det_mag = det_ff[DOT_W-1] ? DOT_W'(-det_ff) : DOT_W'(det_ff);
      d_cand  = det_mag[DEN_W-1:0];
      det_rej = (d_cand == '0) || (d_cand < DEN_W'(eps_ff));
   end

   // barycentric and distance bounds on the sign-folded numerators
   always_comb begin
      d_x  = $signed((DOT_W + 1)'(d_ff));
      un_x = (DOT_W + 1)'(un_ff);
      vn_x = (DOT_W + 1)'(vn_ff);
      tn_x = (DOT_W + 1)'(tn_ff);
      bound_rej = un_ff[DOT_W-1] || (un_x > d_x) ||
                  vn_ff[DOT_W-1] || ((un_x + vn_x) > d_x) ||
                  tn_ff[DOT_W-1] || (tn_x > (d_x <<< 1));
   end

   // divider feed
   always_comb begin
      div_go = (state_ff == S_DIVT) || (state_ff == S_DIVU) || (state_ff == S_DIVV);
      case (state_ff)
         S_DIVU:  div_num = un_ff[NUM_W-1:0];
         S_DIVV:  div_num = vn_ff[NUM_W-1:0];
         default: div_num = tn_ff[NUM_W-1:0];
      endcase
   end

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = (state_ff == S_FIN) && last_ff && rsp_free;
   assign req_stall = (state_ff != S_IDLE);

   rtch_mac u_mac (
      .clock (clock),
      .reset (reset),
      .cmd   (mac_cmd),
      .op_a  (op_a),
      .op_b  (op_b),
      .done  (mac_done),
      .acc   (mac_acc)
   );

   rtch_div u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go),
      .num   (div_num),
      .den   (d_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   // sequencer, ray state, best hit and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         term_ff      <= '0;
         eps_ff       <= EPS_RESET;
         best_t_ff    <= ONE_Q;
         best_u_ff    <= '0;
         best_v_ff    <= '0;
         best_id_ff   <= '0;
         found_ff     <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            org_ff[i] <= '0;
            dir_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            eps_ff <= csr_wr_data;
         end
         // result beat loads when free, drops once taken
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  if (req_cmd == CMD_RAY) begin
                     org_ff[0]  <= req_a_x;
                     org_ff[1]  <= req_a_y;
                     org_ff[2]  <= req_a_z;
                     dir_ff[0]  <= req_b_x;
                     dir_ff[1]  <= req_b_y;
                     dir_ff[2]  <= req_b_z;
                     best_t_ff  <= ONE_Q;
                     best_u_ff  <= '0;
                     best_v_ff  <= '0;
                     best_id_ff <= '0;
                     found_ff   <= 1'b0;
                  end else begin
                     s_ff[0]  <= S_W'(org_ff[0]) - S_W'(req_a_x);
                     s_ff[1]  <= S_W'(org_ff[1]) - S_W'(req_a_y);
                     s_ff[2]  <= S_W'(org_ff[2]) - S_W'(req_a_z);
                     e1_ff[0] <= req_b_x;
                     e1_ff[1] <= req_b_y;
                     e1_ff[2] <= req_b_z;
                     e2_ff[0] <= req_c_x;
                     e2_ff[1] <= req_c_y;
                     e2_ff[2] <= req_c_z;
                     id_ff    <= req_tri_id;
                     last_ff  <= req_last;
                     term_ff  <= '0;
                     state_ff <= S_ISSUE;
                  end
               end
            end
            S_ISSUE: begin
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (mac_done) begin
                  case (term.dest)
                     D_PERP0: perp_ff[0] <= mac_acc[B_W-1:0];
                     D_PERP1: perp_ff[1] <= mac_acc[B_W-1:0];
                     D_PERP2: perp_ff[2] <= mac_acc[B_W-1:0];
                     D_DET:   det_ff     <= mac_acc[DOT_W-1:0];
                     D_Q0:    q_ff[0]    <= mac_acc[B_W-1:0];
                     D_Q1:    q_ff[1]    <= mac_acc[B_W-1:0];
                     D_Q2:    q_ff[2]    <= mac_acc[B_W-1:0];
                     D_UN:    un_ff      <= mac_acc[DOT_W-1:0];
                     D_VN:    vn_ff      <= mac_acc[DOT_W-1:0];
                     default: tn_ff      <= mac_acc[DOT_W-1:0];
                  endcase
                  if (term_ff == TERM_DET_END) begin
                     state_ff <= S_DET;
                  end else if (term_ff == TERM_LAST) begin
                     state_ff <= S_FOLD;
                  end else begin
                     term_ff  <= term_ff + 1'b1;
                     state_ff <= S_ISSUE;
                  end
               end
            end
            S_DET: begin
               neg_ff <= det_ff[DOT_W-1];
               d_ff   <= d_cand;
               if (det_rej) begin
                  state_ff <= S_FIN;
               end else begin
                  term_ff  <= term_ff + 1'b1;
                  state_ff <= S_ISSUE;
               end
            end
            S_FOLD: begin
               if (neg_ff) begin
                  un_ff <= -un_ff;
                  vn_ff <= -vn_ff;
                  tn_ff <= -tn_ff;
               end
               state_ff <= S_CHK;
            end
            S_CHK: begin
               state_ff <= bound_rej ? S_FIN : S_DIVT;
            end
            S_DIVT: begin
               state_ff <= S_WAITT;
            end
            S_WAITT: begin
               if (div_done) begin
                  if (div_quo > best_t_ff) begin
                     state_ff <= S_FIN;
                  end else begin
                     tq_ff    <= div_quo;
                     state_ff <= S_DIVU;
                  end
               end
            end
            S_DIVU: begin
               state_ff <= S_WAITU;
            end
            S_WAITU: begin
               if (div_done) begin
                  uq_ff    <= div_quo;
                  state_ff <= S_DIVV;
               end
            end
            S_DIVV: begin
               state_ff <= S_WAITV;
            end
            S_WAITV: begin
               if (div_done) begin
                  best_t_ff  <= tq_ff;
                  best_u_ff  <= uq_ff;
                  best_v_ff  <= div_quo;
                  best_id_ff <= id_ff;
                  found_ff   <= 1'b1;
                  state_ff   <= S_FIN;
               end
            end
            S_FIN: begin
               if (!last_ff) begin
                  state_ff <= S_IDLE;
               end else if (rsp_free) begin
                  rsp_hit_ff   <= found_ff;
                  rsp_t_ff     <= best_t_ff[RES_W-1:0];
                  rsp_u_ff     <= best_u_ff[RES_W-1:0];
                  rsp_v_ff     <= best_v_ff[RES_W-1:0];
                  rsp_id_ff    <= best_id_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_hit    = rsp_hit_ff;
   assign rsp_hit_t  = rsp_t_ff;
   assign rsp_hit_u  = rsp_u_ff;
   assign rsp_hit_v  = rsp_v_ff;
   assign rsp_hit_id = rsp_id_ff;

endmodule

// ----- rtl/rtch_chk.sv -----
// ----------------------------------------------------------------------------
// rtch_chk: port-level checks of the closest-hit unit
// Watches the handshakes and the result beats seen on the top-level ports.
// ----------------------------------------------------------------------------
module rtch_chk
   import rtch_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      req_cmd,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic                      rsp_hit,
   input logic [RES_W-1:0]          rsp_hit_t,
   input logic [RES_W-1:0]          rsp_hit_u,
   input logic [RES_W-1:0]          rsp_hit_v,
   input logic [ID_BITS-1:0]        rsp_hit_id
);

   localparam logic [RES_W:0] ONE_R = (RES_W + 1)'(ONE_Q);

   // a stalled result beat stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // a triangle beat keeps the unit busy on the next cycle
   a_tri_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_cmd == CMD_TRI) |=> req_stall)
      else $error("unit ready right after a triangle beat");

   // a miss reports the far end with cleared fields
   a_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |->
         ({1'b0, rsp_hit_t} == ONE_R) && (rsp_hit_u == '0) &&
         (rsp_hit_v == '0) && (rsp_hit_id == '0))
      else $error("miss beat with hit fields set");

   // a hit lies within range and inside the triangle
   a_hit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |->
         ({1'b0, rsp_hit_t} <= ONE_R) &&
         (({1'b0, rsp_hit_u} + {1'b0, rsp_hit_v}) <= ONE_R))
      else $error("hit beat out of range");

endmodule

bind ray_triangle_closest_hit_unit rtch_chk u_rtch_chk (.*);
